### rtl/sfat_pkg.sv
package sfat_pkg;

	localparam int unsigned LEN_W   = 4;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SPEED_W = 13;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SAVES_W = 2;

	localparam logic [LEN_W-1:0]   MIN_LENGTH      = 4'd3;
	localparam logic [COUNT_W-1:0] STEADY_MAX      = 8'd200;
	localparam logic [SPEED_W-1:0] LOW_TARGET      = 13'd1600;
	localparam logic [SPEED_W-1:0] HIGH_TARGET     = 13'd3200;
	localparam logic [TIME_W-1:0]  LOW_LIMIT_MS    = 32'd20000;
	localparam logic [TIME_W-1:0]  HIGH_LIMIT_MS   = 32'd40000;
	localparam logic [TIME_W-1:0]  START_OFFSET_MS = 32'd10;

	typedef struct packed {
		logic               accepted;
		logic               brake;
		logic [SPEED_W-1:0] speed;
		logic [TIME_W-1:0]  now_ms;
	} frame_word_t;

	typedef struct packed {
		logic               accepted;
		logic               brake_intervention;
		logic [SPEED_W-1:0] speed_sixteenths;
		logic [COUNT_W-1:0] steady_count;
		logic               low_run_active;
		logic [TIME_W-1:0]  low_run_elapsed_ms;
		logic               high_run_active;
		logic [TIME_W-1:0]  high_run_elapsed_ms;
		logic [SAVES_W-1:0] save_requests;
	} result_word_t;

endpackage

### rtl/sfat_front.sv
module sfat_front (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sfat_pkg::LEN_W-1:0]   frame_length,
	input  logic [sfat_pkg::BYTE_W-1:0]  byte_zero,
	input  logic [sfat_pkg::BYTE_W-1:0]  byte_one,
	input  logic [sfat_pkg::BYTE_W-1:0]  byte_two,
	input  logic [sfat_pkg::TIME_W-1:0]  now_ms,
	output logic                         push_valid,
	input  logic                         push_ready,
	output sfat_pkg::frame_word_t        push_word
);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// classify length and unpack brake and speed bits
	always_comb begin
		push_word.accepted = (frame_length >= sfat_pkg::MIN_LENGTH);
		push_word.brake    = byte_zero[5];
		push_word.speed    = {byte_zero[1:0], byte_one, byte_two[7:5]};
		push_word.now_ms   = now_ms;
	end

endmodule

### rtl/sfat_queue.sv
module sfat_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  sfat_pkg::frame_word_t push_word,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output sfat_pkg::frame_word_t pop_word
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sfat_pkg::frame_word_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_word   = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/sfat_back.sv
module sfat_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  sfat_pkg::frame_word_t  pop_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sfat_pkg::result_word_t result
);

	logic [sfat_pkg::SPEED_W-1:0] prev_speed_q;
	logic [sfat_pkg::COUNT_W-1:0] steady_q;
	logic                         low_running_q;
	logic [sfat_pkg::TIME_W-1:0]  low_start_q;
	logic [sfat_pkg::TIME_W-1:0]  low_elapsed_q;
	logic                         high_running_q;
	logic [sfat_pkg::TIME_W-1:0]  high_start_q;
	logic [sfat_pkg::TIME_W-1:0]  high_elapsed_q;
	logic                         brake_q;
	logic                         out_valid_q;
	sfat_pkg::result_word_t       result_q;

	logic                         pop_fire;
	logic [sfat_pkg::SPEED_W-1:0] raw;
	logic [sfat_pkg::TIME_W-1:0]  start_time;
	logic                         low_start;
	logic                         low_run;
	logic [sfat_pkg::TIME_W-1:0]  low_elapsed;
	logic                         low_hit;
	logic                         high_start;
	logic                         high_run;
	logic [sfat_pkg::TIME_W-1:0]  high_elapsed;
	logic                         high_hit;
	sfat_pkg::result_word_t       next_result;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop_fire  = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign raw        = pop_word.speed;
	assign start_time = pop_word.now_ms - sfat_pkg::START_OFFSET_MS;

	// low run: 0 to 100 km/h
	assign low_start   = (prev_speed_q == '0) && (raw != '0);
	assign low_run     = low_running_q || low_start;
	assign low_elapsed = low_start ? sfat_pkg::START_OFFSET_MS
	                               : pop_word.now_ms - low_start_q;
	assign low_hit     = low_run && (raw >= sfat_pkg::LOW_TARGET);

	// high run: 100 to 200 km/h
	assign high_start   = (prev_speed_q <= sfat_pkg::LOW_TARGET)
	                   && (raw > sfat_pkg::LOW_TARGET);
	assign high_run     = high_running_q || high_start;
	assign high_elapsed = high_start ? sfat_pkg::START_OFFSET_MS
	                                 : pop_word.now_ms - high_start_q;
	assign high_hit     = high_run && (raw >= sfat_pkg::HIGH_TARGET);

	always_comb begin
		next_result.accepted            = 1'b0;
		next_result.brake_intervention  = brake_q;
		next_result.speed_sixteenths    = prev_speed_q;
		next_result.steady_count        = steady_q;
		next_result.low_run_active      = low_running_q;
		next_result.low_run_elapsed_ms  = low_elapsed_q;
		next_result.high_run_active     = high_running_q;
		next_result.high_run_elapsed_ms = high_elapsed_q;
		next_result.save_requests       = '0;
		if (pop_word.accepted) begin
			next_result.accepted           = 1'b1;
			next_result.brake_intervention = pop_word.brake;
			next_result.speed_sixteenths   = raw;
			if (raw != '0) begin
				next_result.steady_count = '0;
			end else if (steady_q < sfat_pkg::STEADY_MAX) begin
				next_result.steady_count = steady_q + 1'b1;
			end else begin
				next_result.steady_count = sfat_pkg::STEADY_MAX;
			end
			if (low_run) begin
				next_result.low_run_elapsed_ms = low_elapsed;
				next_result.low_run_active     = !low_hit
				                              && (low_elapsed <= sfat_pkg::LOW_LIMIT_MS);
			end
			if (high_run) begin
				next_result.high_run_elapsed_ms = high_elapsed;
				next_result.high_run_active     = !high_hit
				                               && (high_elapsed <= sfat_pkg::HIGH_LIMIT_MS);
			end
			next_result.save_requests = {1'b0, low_hit} + {1'b0, high_hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_speed_q   <= '0;
			steady_q       <= '0;
			low_running_q  <= 1'b0;
			low_start_q    <= '0;
			low_elapsed_q  <= '0;
			high_running_q <= 1'b0;
			high_start_q   <= '0;
			high_elapsed_q <= '0;
			brake_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_fire && pop_word.accepted) begin
				prev_speed_q   <= next_result.speed_sixteenths;
				steady_q       <= next_result.steady_count;
				brake_q        <= next_result.brake_intervention;
				low_running_q  <= next_result.low_run_active;
				low_elapsed_q  <= next_result.low_run_elapsed_ms;
				high_running_q <= next_result.high_run_active;
				high_elapsed_q <= next_result.high_run_elapsed_ms;
				if (low_start) begin
					low_start_q <= start_time;
				end
				if (high_start) begin
					high_start_q <= start_time;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			result_q <= next_result;
		end
	end

	a_steady_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steady_q <= sfat_pkg::STEADY_MAX)
		else $error("steady count above limit");

	a_low_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		low_running_q |-> (prev_speed_q < sfat_pkg::LOW_TARGET))
		else $error("low run active at target speed");

	a_high_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		high_running_q |-> (prev_speed_q < sfat_pkg::HIGH_TARGET))
		else $error("high run active at target speed");

	a_save_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.save_requests != '0)) |-> result_q.accepted)
		else $error("save request on ignored frame");

endmodule

### rtl/speed_frame_accel_timer_top.sv
// channel | direction | handshake            | fields
// input   | in        | in_valid / in_ready  | frame_length byte_zero byte_one byte_two now_ms
// output  | out       | out_valid / out_ready| accepted .. save_requests
//
// one word per cycle sustained while out_ready stays high
// front decodes into a small queue, back updates timers and loads one output register
// arst_n clears speed, counter, timers, queue and output valid
// input stalls only when the queue is full; output stall holds the result register
module speed_frame_accel_timer_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sfat_pkg::LEN_W-1:0]   frame_length,
	input  logic [sfat_pkg::BYTE_W-1:0]  byte_zero,
	input  logic [sfat_pkg::BYTE_W-1:0]  byte_one,
	input  logic [sfat_pkg::BYTE_W-1:0]  byte_two,
	input  logic [sfat_pkg::TIME_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         accepted,
	output logic                         brake_intervention,
	output logic [sfat_pkg::SPEED_W-1:0] speed_sixteenths,
	output logic [sfat_pkg::COUNT_W-1:0] steady_count,
	output logic                         low_run_active,
	output logic [sfat_pkg::TIME_W-1:0]  low_run_elapsed_ms,
	output logic                         high_run_active,
	output logic [sfat_pkg::TIME_W-1:0]  high_run_elapsed_ms,
	output logic [sfat_pkg::SAVES_W-1:0] save_requests
);

	logic                   push_valid;
	logic                   push_ready;
	sfat_pkg::frame_word_t  push_word;
	logic                   pop_valid;
	logic                   pop_ready;
	sfat_pkg::frame_word_t  pop_word;
	sfat_pkg::result_word_t result;

	sfat_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.frame_length (frame_length),
		.byte_zero    (byte_zero),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.now_ms       (now_ms),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_word    (push_word)
	);

	sfat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	sfat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_word  (pop_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign accepted            = result.accepted;
	assign brake_intervention  = result.brake_intervention;
	assign speed_sixteenths    = result.speed_sixteenths;
	assign steady_count        = result.steady_count;
	assign low_run_active      = result.low_run_active;
	assign low_run_elapsed_ms  = result.low_run_elapsed_ms;
	assign high_run_active     = result.high_run_active;
	assign high_run_elapsed_ms = result.high_run_elapsed_ms;
	assign save_requests       = result.save_requests;

endmodule
